// ----- rtl/pxocc_pkg.sv -----
// ----------------------------------------------------------------------------
// pxocc_pkg
// Shared codes and stage payload types for the pixel to occupancy cell pipe.
// ----------------------------------------------------------------------------
package pxocc_pkg;

    // Conversion rules (conversion rule register); code 3 gives unknown cells
    localparam logic [1:0] MODE_TRINARY = 2'd0;
    localparam logic [1:0] MODE_SCALE   = 2'd1;
    localparam logic [1:0] MODE_RAW     = 2'd2;

    // Colour formats (color_format register); code 3 is taken as gray
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_BGR  = 2'd1;
    localparam logic [1:0] FMT_BGRA = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CONV_RULE  = 3'd0;
    localparam logic [2:0] REG_NEGATE     = 3'd1;
    localparam logic [2:0] REG_FREE_TH    = 3'd2;
    localparam logic [2:0] REG_OCC_TH     = 3'd3;
    localparam logic [2:0] REG_COLOR_FMT  = 3'd4;
    localparam logic [2:0] REG_MAP_WIDTH  = 3'd5;
    localparam logic [2:0] REG_MAP_HEIGHT = 3'd6;

    // Cell values
    localparam logic signed [7:0] CELL_UNKNOWN  = -8'sd1;
    localparam logic signed [7:0] CELL_FREE     = 8'sd0;
    localparam logic signed [7:0] CELL_OCCUPIED = 8'sd100;

    // Quotient bits of the scale divider (quotient never exceeds 100)
    localparam int QBITS = 7;

    // Floor of x/6 for x below 2048 as (x * RECIP6) >> 16
    localparam logic [13:0] RECIP6 = 14'd10923;

    typedef struct packed {
        logic [9:0]  sum;
        logic [9:0]  den;
        logic [9:0]  o_num;
        logic        gray;
        logic        transparent;
        logic [23:0] row_off;
        logic [11:0] column;
    } t_s1;

    typedef struct packed {
        logic [26:0] occ_den;
        logic [26:0] free_den;
        logic [25:0] o_sh;
        logic        transparent;
        logic [7:0]  pct;
        logic [23:0] addr_prod;
        logic [11:0] column;
    } t_s2;

    typedef struct packed {
        logic        above;
        logic        below;
        logic        transparent;
        logic [7:0]  pct;
        logic [26:0] diff;
        logic [26:0] bot;
        logic [23:0] addr;
    } t_s3;

    typedef struct packed {
        logic        above;
        logic        below;
        logic        transparent;
        logic [7:0]  pct;
        logic [33:0] rem;
        logic [26:0] bot;
        logic [QBITS-1:0] quot;
        logic [23:0] addr;
    } t_div;

endpackage

// ----- rtl/pixel_to_occupancy_cell.sv -----
// ----------------------------------------------------------------------------
// pixel_to_occupancy_cell
// Converts one map image pixel and its position into one occupancy grid cell
// value and the cell's address in a grid stored bottom row first. The block is
// a twelve stage pipeline that takes one pixel beat every cycle unless
// o_in_stall is raised, and presents the cell beats on the output in order;
// the length is set by the scale-mode rounding divider, which resolves one
// quotient bit per stage over seven stages. A stall on the result side
// holds only the stages that are full: empty stages keep filling, so the
// input keeps taking beats until the pipe is full. Shade is the channel
// mean (inverted alpha joins it in trinary mode for BGRA), occupancy is the
// shade or one minus it, and all threshold tests are exact integer products
// against the Q16 thresholds. Configuration registers are written through
// their own port, always ready, and must only change while no beat is in
// flight. Width and height writes take the low 13 data bits, and values
// above the smaller of MAX_DIMENSION and 8191 saturate to that value;
// addresses wrap modulo 2^24.
// ----------------------------------------------------------------------------
module pixel_to_occupancy_cell #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // pixel channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_red_or_gray,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic [7:0]         i_alpha,
    input  logic [11:0]        i_column,
    input  logic [11:0]        i_row,
    // cell channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [7:0]  o_cell_value,
    output logic [23:0]        o_cell_address,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    // Saturation value for the dimension registers, limited to their width
    localparam int          CAP_INT = (MAX_DIMENSION > 8191) ? 8191 : MAX_DIMENSION;
    localparam logic [12:0] DIM_CAP = 13'(CAP_INT);

    localparam int QB      = pxocc_pkg::QBITS;
    localparam int DIV0    = 4;          // first divider stage in the valid chain
    localparam int NSTAGES = DIV0 + QB + 1;
    localparam int LAST    = NSTAGES - 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  r_conv_rule;
    logic        r_negate;
    logic [16:0] r_free_th;
    logic [16:0] r_occ_th;
    logic [1:0]  r_color_fmt;
    logic [12:0] r_map_width;
    logic [12:0] r_map_height;
    logic [12:0] n_dim;

    assign o_cfg_ready = 1'b1;

    // Saturate an oversized dimension write
    always_comb begin
        n_dim = i_cfg_data[12:0];
        if ({19'd0, i_cfg_data[12:0]} > 32'(CAP_INT)) begin
            n_dim = DIM_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_rule  <= pxocc_pkg::MODE_TRINARY;
            r_negate     <= 1'b0;
            r_free_th    <= 17'd16384;
            r_occ_th     <= 17'd42598;
            r_color_fmt  <= pxocc_pkg::FMT_GRAY;
            r_map_width  <= 13'd1;
            r_map_height <= 13'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pxocc_pkg::REG_CONV_RULE:  r_conv_rule  <= i_cfg_data[1:0];
                pxocc_pkg::REG_NEGATE:     r_negate     <= i_cfg_data[0];
                pxocc_pkg::REG_FREE_TH:    r_free_th    <= i_cfg_data;
                pxocc_pkg::REG_OCC_TH:     r_occ_th     <= i_cfg_data;
                pxocc_pkg::REG_COLOR_FMT:  r_color_fmt  <= i_cfg_data[1:0];
                pxocc_pkg::REG_MAP_WIDTH:  r_map_width  <= n_dim;
                pxocc_pkg::REG_MAP_HEIGHT: r_map_height <= n_dim;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage takes new data when it is empty or when the
    // stage after it is moving. Empty stages therefore keep filling while
    // the output is stalled.
    // ------------------------------------------------------------------
    logic [LAST:0]   r_vld;
    logic [NSTAGES:0] w_adv;

    assign w_adv[NSTAGES] = !i_out_stall;

    for (genvar k = 0; k < NSTAGES; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    assign o_in_stall  = !w_adv[0];
    assign o_out_valid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: channel sum, denominator, occupancy numerator, row offset
    // ------------------------------------------------------------------
    pxocc_pkg::t_s1 n_s1, r_s1;
    logic           w_rgb;
    logic           w_bgra;

    always_comb begin
        w_rgb  = (r_color_fmt == pxocc_pkg::FMT_BGR) || (r_color_fmt == pxocc_pkg::FMT_BGRA);
        w_bgra = (r_color_fmt == pxocc_pkg::FMT_BGRA);

        n_s1             = '0;
        n_s1.gray        = !w_rgb;
        n_s1.transparent = w_bgra && (i_alpha != 8'hFF);
        if (!w_rgb) begin
            n_s1.sum = 10'(i_red_or_gray);
            n_s1.den = 10'd255;
        end else if (w_bgra && (r_conv_rule == pxocc_pkg::MODE_TRINARY)) begin
            // inverted alpha counts as a fourth channel
            n_s1.sum = 10'(i_red_or_gray) + 10'(i_green) + 10'(i_blue)
                     + 10'(8'hFF - i_alpha);
            n_s1.den = 10'd1020;
        end else begin
            n_s1.sum = 10'(i_red_or_gray) + 10'(i_green) + 10'(i_blue);
            n_s1.den = 10'd765;
        end
        n_s1.o_num   = r_negate ? n_s1.sum : (n_s1.den - n_s1.sum);
        // height - row - 1, wrapping
        n_s1.row_off = 24'(r_map_height) - 24'(i_row) - 24'd1;
        n_s1.column  = i_column;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1 <= n_s1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: threshold products, raw percentage, address product
    // ------------------------------------------------------------------
    pxocc_pkg::t_s2 n_s2, r_s2;
    logic [10:0]    w_raw_x;
    logic [24:0]    w_raw_prod;
    logic [36:0]    w_addr_full;

    always_comb begin
        n_s2             = '0;
        n_s2.occ_den     = 27'(r_occ_th) * 27'(r_s1.den);
        n_s2.free_den    = 27'(r_free_th) * 27'(r_s1.den);
        n_s2.o_sh        = {r_s1.o_num, 16'd0};
        n_s2.transparent = r_s1.transparent;
        // raw mode with three channels: (2*sum + 3) / 6, rounded half up
        w_raw_x    = {r_s1.sum, 1'b0} + 11'd3;
        w_raw_prod = 25'(w_raw_x) * 25'(pxocc_pkg::RECIP6);
        n_s2.pct   = r_s1.gray ? r_s1.sum[7:0] : w_raw_prod[23:16];
        w_addr_full    = 37'(r_map_width) * 37'(r_s1.row_off);
        n_s2.addr_prod = w_addr_full[23:0];
        n_s2.column    = r_s1.column;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2 <= n_s2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compare against thresholds, form dividend and divisor bases
    // ------------------------------------------------------------------
    pxocc_pkg::t_s3 n_s3, r_s3;

    always_comb begin
        n_s3             = '0;
        n_s3.above       = r_s2.occ_den < 27'(r_s2.o_sh);
        n_s3.below       = 27'(r_s2.o_sh) < r_s2.free_den;
        n_s3.transparent = r_s2.transparent;
        n_s3.pct         = r_s2.pct;
        // only meaningful between the thresholds, where neither goes negative
        n_s3.diff        = 27'(r_s2.o_sh) - r_s2.free_den;
        n_s3.bot         = r_s2.occ_den - r_s2.free_den;
        n_s3.addr        = r_s2.addr_prod + 24'(r_s2.column);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3 <= n_s3;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: scale the dividend by 100
    // ------------------------------------------------------------------
    pxocc_pkg::t_div n_s4, r_s4;

    always_comb begin
        n_s4             = '0;
        n_s4.above       = r_s3.above;
        n_s4.below       = r_s3.below;
        n_s4.transparent = r_s3.transparent;
        n_s4.pct         = r_s3.pct;
        n_s4.rem         = 34'(r_s3.diff) * 34'(100);
        n_s4.bot         = r_s3.bot;
        n_s4.quot        = '0;
        n_s4.addr        = r_s3.addr;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s4 <= n_s4;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one restoring step per stage, most significant bit first
    // ------------------------------------------------------------------
    pxocc_pkg::t_div r_dv [QB];

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int BIT = QB - 1 - j;

        pxocc_pkg::t_div w_in;
        pxocc_pkg::t_div n_dv;
        logic [33:0]     w_trial;

        if (j == 0) begin : g_first
            assign w_in = r_s4;
        end else begin : g_next
            assign w_in = r_dv[j-1];
        end

        always_comb begin
            n_dv    = w_in;
            w_trial = 34'(w_in.bot) << BIT;
            if (w_in.rem >= w_trial) begin
                n_dv.rem       = w_in.rem - w_trial;
                n_dv.quot[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[DIV0 + j]) begin
                r_dv[j] <= n_dv;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: round half to even, pick the cell value by mode
    // ------------------------------------------------------------------
    pxocc_pkg::t_div  w_fin;
    logic [34:0]      w_two_r;
    logic             w_round_up;
    logic [QB-1:0]    w_qr;
    logic signed [7:0] w_scaled;
    logic signed [7:0] n_cell;
    logic signed [7:0] r_cell;
    logic [23:0]      r_addr;

    assign w_fin = r_dv[QB-1];

    always_comb begin
        w_two_r    = {w_fin.rem, 1'b0};
        w_round_up = (w_two_r > 35'(w_fin.bot))
                  || ((w_two_r == 35'(w_fin.bot)) && w_fin.quot[0]);
        w_qr       = w_fin.quot + QB'(w_round_up);
        // equal thresholds leave nothing to scale: give free
        w_scaled   = (w_fin.bot == '0) ? pxocc_pkg::CELL_FREE : 8'(w_qr);

        unique case (r_conv_rule)
            pxocc_pkg::MODE_TRINARY: begin
                if (w_fin.above) begin
                    n_cell = pxocc_pkg::CELL_OCCUPIED;
                end else if (w_fin.below) begin
                    n_cell = pxocc_pkg::CELL_FREE;
                end else begin
                    n_cell = pxocc_pkg::CELL_UNKNOWN;
                end
            end
            pxocc_pkg::MODE_SCALE: begin
                if (w_fin.transparent) begin
                    n_cell = pxocc_pkg::CELL_UNKNOWN;
                end else if (w_fin.above) begin
                    n_cell = pxocc_pkg::CELL_OCCUPIED;
                end else if (w_fin.below) begin
                    n_cell = pxocc_pkg::CELL_FREE;
                end else begin
                    n_cell = w_scaled;
                end
            end
            pxocc_pkg::MODE_RAW: begin
                n_cell = (w_fin.pct <= 8'd100) ? signed'(w_fin.pct)
                                               : pxocc_pkg::CELL_UNKNOWN;
            end
            default: begin
                n_cell = pxocc_pkg::CELL_UNKNOWN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[LAST]) begin
            r_cell <= n_cell;
            r_addr <= w_fin.addr;
        end
    end

    assign o_cell_value   = r_cell;
    assign o_cell_address = r_addr;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pixel to occupancy cell pipe. Pixel beats are
// pushed through the pixel channel while a local model works out the cell
// value and grid address of every accepted beat; each cell beat that leaves
// the block is checked in order against those predictions. Directed phases
// cover the corner settings, then randomised phases sweep the registers and
// the pixel space with random idling on both channels and a stretch at full
// rate.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          MAX_DIM     = 4096;
    localparam int          STUCK_LIMIT = 5000;
    localparam int          TAIL_CYCLES = 40;
    localparam int          SHOW_LIMIT  = 10;
    // no register lives at this index; writes to it must leave all alone
    localparam logic [2:0]  REG_SPARE   = 3'd7;
    // codes with no rule or format of their own behind them
    localparam logic [1:0]  MODE_SPARE  = 2'd3;
    localparam logic [1:0]  FMT_SPARE   = 2'd3;
    localparam logic [16:0] TH_ONE      = 17'd65536;
    localparam logic [16:0] TH_TOP      = 17'h1FFFF;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
    } pixel_t;

    typedef struct packed {
        logic signed [7:0] value;
        logic [23:0]       address;
    } cell_t;

    // ------------------------------------------------------------------------
    // Clock, reset and driven inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic [7:0]         i_red_or_gray = '0;
    logic [7:0]         i_green       = '0;
    logic [7:0]         i_blue        = '0;
    logic [7:0]         i_alpha       = '0;
    logic [11:0]        i_column      = '0;
    logic [11:0]        i_row         = '0;
    logic               i_out_stall   = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic [2:0]         i_cfg_index   = '0;
    logic [16:0]        i_cfg_data    = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [7:0]  o_cell_value;
    logic [23:0]        o_cell_address;
    logic               o_cfg_ready;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pixel_to_occupancy_cell #(
        .MAX_DIMENSION (MAX_DIM)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_red_or_gray  (i_red_or_gray),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_alpha        (i_alpha),
        .i_column       (i_column),
        .i_row          (i_row),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_cell_value   (o_cell_value),
        .o_cell_address (o_cell_address),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Local copy of the registers, kept at their reset values until written
    // ------------------------------------------------------------------------
    logic [1:0]  cfg_mode   = pxocc_pkg::MODE_TRINARY;
    logic        cfg_negate = 1'b0;
    logic [16:0] cfg_free   = 17'd16384;
    logic [16:0] cfg_occ    = 17'd42598;
    logic [1:0]  cfg_format = pxocc_pkg::FMT_GRAY;
    logic [31:0] cfg_width  = 32'd1;
    logic [31:0] cfg_height = 32'd1;

    cell_t       pending_cells[$];
    int          mismatches   = 0;
    int          stuck_cycles = 0;
    bit          pixel_idling = 1'b1;
    bit          cell_idling  = 1'b1;

    // Saturate a dimension write: only the low 13 bits count, capped at MAX_DIM
    function automatic logic [31:0] clip_dimension(input logic [16:0] data);
        logic [31:0] dim;
        dim = {19'd0, data[12:0]};
        if (dim > MAX_DIM)
            dim = MAX_DIM;
        return dim;
    endfunction

    // Work out the cell that one pixel must turn into under the current setup.
    // All tests are exact: occupancy is o_num / den, thresholds are T / 65536.
    function automatic cell_t occupancy_of(input pixel_t px);
        logic [63:0] sum, n, den, o_num, o_sh, occ_den, free_den;
        logic [63:0] top, bot, q, r, pct;
        logic [31:0] addr;
        logic        transparent;
        cell_t       res;
        transparent = 1'b0;
        if (cfg_format == pxocc_pkg::FMT_BGR || cfg_format == pxocc_pkg::FMT_BGRA) begin
            sum = 64'(px.red) + 64'(px.green) + 64'(px.blue);
            n   = 64'd3;
            if (cfg_format == pxocc_pkg::FMT_BGRA) begin
                transparent = (px.alpha != 8'hFF);
                // inverted alpha joins the mean in trinary mode only
                if (cfg_mode == pxocc_pkg::MODE_TRINARY) begin
                    sum = sum + 64'd255 - 64'(px.alpha);
                    n   = 64'd4;
                end
            end
        end else begin
            // gray, and the unused format code falls back to gray
            sum = 64'(px.red);
            n   = 64'd1;
        end
        den      = 64'd255 * n;
        o_num    = cfg_negate ? sum : den - sum;
        o_sh     = o_num << 16;
        occ_den  = 64'(cfg_occ) * den;
        free_den = 64'(cfg_free) * den;
        res.value = pxocc_pkg::CELL_UNKNOWN;
        if (cfg_mode == pxocc_pkg::MODE_TRINARY || cfg_mode == pxocc_pkg::MODE_SCALE) begin
            if (cfg_mode == pxocc_pkg::MODE_SCALE && transparent)
                res.value = pxocc_pkg::CELL_UNKNOWN;
            else if (occ_den < o_sh)
                res.value = pxocc_pkg::CELL_OCCUPIED;
            else if (o_sh < free_den)
                res.value = pxocc_pkg::CELL_FREE;
            else if (cfg_mode == pxocc_pkg::MODE_SCALE) begin
                top = (o_sh - free_den) * 64'd100;
                bot = (64'(cfg_occ) - 64'(cfg_free)) * den;
                if (bot == 64'd0) begin
                    // both thresholds hit exactly: the span is empty
                    q = 64'd0;
                end else begin
                    q = top / bot;
                    r = top % bot;
                    // round to nearest, ties to even
                    if (2 * r > bot || (2 * r == bot && q[0]))
                        q = q + 64'd1;
                end
                res.value = q[7:0];
            end
        end else if (cfg_mode == pxocc_pkg::MODE_RAW) begin
            pct = (64'd2 * sum + n) / (64'd2 * n);
            res.value = (pct <= 64'd100) ? pct[7:0] : pxocc_pkg::CELL_UNKNOWN;
        end
        // bottom row first; out-of-map positions simply wrap
        addr = cfg_width * (cfg_height - 32'(px.row) - 32'd1) + 32'(px.column);
        res.address = addr[23:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Beat monitor: predict on every pixel beat, check every cell beat, follow
    // register writes, and count cycles in which nothing moves
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit     moved;
        pixel_t px;
        cell_t  want;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                px = '{i_red_or_gray, i_green, i_blue, i_alpha, i_column, i_row};
                pending_cells = {pending_cells, occupancy_of(px)};
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_cells.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("%0t: cell beat with none pending: value %0d address %0h",
                                 $realtime, o_cell_value, o_cell_address);
                end else begin
                    want = pending_cells.pop_front();
                    if (o_cell_value !== want.value || o_cell_address !== want.address) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display("%0t: cell mismatch: expected %0d @ %0h, got %0d @ %0h",
                                     $realtime, want.value, want.address,
                                     o_cell_value, o_cell_address);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    pxocc_pkg::REG_CONV_RULE:  cfg_mode   = i_cfg_data[1:0];
                    pxocc_pkg::REG_NEGATE:     cfg_negate = i_cfg_data[0];
                    pxocc_pkg::REG_FREE_TH:    cfg_free   = i_cfg_data;
                    pxocc_pkg::REG_OCC_TH:     cfg_occ    = i_cfg_data;
                    pxocc_pkg::REG_COLOR_FMT:  cfg_format = i_cfg_data[1:0];
                    pxocc_pkg::REG_MAP_WIDTH:  cfg_width  = clip_dimension(i_cfg_data);
                    pxocc_pkg::REG_MAP_HEIGHT: cfg_height = clip_dimension(i_cfg_data);
                    default: ;
                endcase
            end
            stuck_cycles <= moved ? 0 : stuck_cycles + 1;
        end
    end

    // Stall the cell side at random while idling is on
    always @(negedge i_clk) begin
        i_out_stall <= cell_idling && ($urandom_range(0, 99) < 38);
    end

    // Watchdog: end the run if the pipe stops moving
    initial begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Present one pixel beat and hold it until taken; valid stays high after
    // the beat so that back-to-back beats never drop it in between
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] alpha,
                              input logic [11:0] column, input logic [11:0] row);
        while (pixel_idling && $urandom_range(0, 99) < 38) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_red_or_gray <= red;
        i_green       <= green;
        i_blue        <= blue;
        i_alpha       <= alpha;
        i_column      <= column;
        i_row         <= row;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop pixel valid and wait until every pending cell beat has come back
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [16:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_setup(input logic [1:0] mode, input logic negate,
                               input logic [16:0] free_th, input logic [16:0] occ_th,
                               input logic [1:0] format, input logic [16:0] width,
                               input logic [16:0] height);
        drain_pipe();
        write_reg(pxocc_pkg::REG_CONV_RULE, 17'(mode));
        write_reg(pxocc_pkg::REG_NEGATE, 17'(negate));
        write_reg(pxocc_pkg::REG_FREE_TH, free_th);
        write_reg(pxocc_pkg::REG_OCC_TH, occ_th);
        write_reg(pxocc_pkg::REG_COLOR_FMT, 17'(format));
        write_reg(pxocc_pkg::REG_MAP_WIDTH, width);
        write_reg(pxocc_pkg::REG_MAP_HEIGHT, height);
    endtask

    function automatic logic [16:0] threshold_corner();
        case ($urandom_range(0, 2))
            0:       return 17'd0;
            1:       return TH_ONE;
            default: return TH_TOP;
        endcase
    endfunction

    function automatic logic [16:0] random_dimension();
        case ($urandom_range(0, 9))
            0:       return 17'(MAX_DIM);
            1:       return 17'($urandom_range(MAX_DIM + 1, 8191));
            2:       return 17'($urandom_range(1, MAX_DIM));
            default: return 17'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [7:0] random_channel();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Pick a fresh random setup; most of it sane, some of it at the corners
    task automatic randomise_setup();
        logic [1:0]  mode, format;
        logic [16:0] free_th, occ_th;
        mode   = ($urandom_range(0, 9) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
        format = ($urandom_range(0, 9) == 0) ? FMT_SPARE : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
            0: begin
                free_th = 17'($urandom_range(0, 65536));
                occ_th  = free_th;
            end
            1: begin
                occ_th  = 17'($urandom_range(0, 65536));
                free_th = 17'($urandom_range(occ_th, TH_TOP));
            end
            2: begin
                free_th = threshold_corner();
                occ_th  = threshold_corner();
            end
            default: begin
                free_th = 17'($urandom_range(0, 50000));
                occ_th  = 17'($urandom_range(free_th, 65536));
            end
        endcase
        write_setup(mode, 1'($urandom_range(0, 1)), free_th, occ_th, format,
                    random_dimension(), random_dimension());
        if ($urandom_range(0, 4) == 0)
            write_reg(REG_SPARE, 17'($urandom_range(0, TH_TOP)));
    endtask

    // Send pixels mostly inside the map, now and then anywhere at all
    task automatic send_random_pixels(input int count);
        logic [11:0] column, row;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                column = 12'($urandom_range(0, 4095));
                row    = 12'($urandom_range(0, 4095));
            end else begin
                column = 12'($urandom_range(0, cfg_width - 1));
                row    = 12'($urandom_range(0, cfg_height - 1));
            end
            send_pixel(random_channel(), random_channel(), random_channel(),
                       ($urandom_range(0, 9) < 4) ? 8'hFF : random_channel(),
                       column, row);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset setup: trinary, gray, width and height of one
    task automatic test_reset_values();
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        send_pixel(8'd128, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        // row past the map: the address wraps
        send_pixel(8'd64, 8'hFF, 8'hFF, 8'hFF, 12'd3, 12'd5);
    endtask

    // Scale mode on BGRA with an oversized width that must saturate
    task automatic test_scale_bgra();
        write_setup(pxocc_pkg::MODE_SCALE, 1'b0, 17'd16384, 17'd42598,
                    pxocc_pkg::FMT_BGRA, 17'd8191, 17'(MAX_DIM));
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd0, 12'd4095);
        send_pixel(8'd100, 8'd150, 8'd200, 8'd255, 12'd17, 12'd300);
        send_pixel(8'd10, 8'd20, 8'd30, 8'd255, 12'd2048, 12'd2047);
    endtask

    // Equal thresholds in scale, then thresholds beyond one and crossed
    task automatic test_threshold_corners();
        write_setup(pxocc_pkg::MODE_SCALE, 1'b0, TH_ONE, TH_ONE, pxocc_pkg::FMT_GRAY,
                    17'd7, 17'd9);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd6, 12'd8);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd0, 12'd1, 12'd1);
        write_setup(pxocc_pkg::MODE_TRINARY, 1'b1, TH_TOP, 17'd0, pxocc_pkg::FMT_BGR,
                    17'd640, 17'd480);
        write_reg(REG_SPARE, TH_TOP);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 12'd639, 12'd479);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 12'd0, 12'd0);
        send_pixel(8'd90, 8'd128, 8'd17, 8'd99, 12'd320, 12'd240);
    endtask

    // Raw mode on the unused format code and on BGR, then the unused mode
    task automatic test_raw_and_unused_codes();
        write_setup(pxocc_pkg::MODE_RAW, 1'b0, 17'd16384, 17'd42598, FMT_SPARE,
                    17'd1, 17'd1);
        send_pixel(8'd0, 8'd200, 8'd200, 8'd0, 12'd0, 12'd0);
        send_pixel(8'd100, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        send_pixel(8'd101, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0);
        write_setup(pxocc_pkg::MODE_RAW, 1'b1, 17'd0, TH_ONE, pxocc_pkg::FMT_BGR,
                    17'd100, 17'd100);
        send_pixel(8'd100, 8'd100, 8'd101, 8'd0, 12'd99, 12'd0);
        send_pixel(8'd0, 8'd0, 8'd1, 8'd0, 12'd0, 12'd99);
        write_setup(MODE_SPARE, 1'b0, 17'd16384, 17'd42598, pxocc_pkg::FMT_BGRA,
                    17'd1, 17'd1);
        send_pixel(8'd10, 8'd10, 8'd10, 8'd255, 12'd0, 12'd0);
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 14; p++) begin
            randomise_setup();
            send_random_pixels(50);
        end
    endtask

    // Long stretch with no idling on either side
    task automatic test_full_rate();
        pixel_idling = 1'b0;
        cell_idling  = 1'b0;
        for (int p = 0; p < 2; p++) begin
            randomise_setup();
            send_random_pixels(80);
        end
        pixel_idling = 1'b1;
        cell_idling  = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_scale_bgra();
        test_threshold_corners();
        test_raw_and_unused_codes();
        test_random_traffic();
        test_full_rate();

        // let stray beats surface after the last one is back
        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_cells.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
